[src/mda_pkg.sv]
// ----------------------------------------------------------------------------
// mda_pkg: shared types and constants of the multidimensional array store
// Rank, register map, access status codes and the per-stage control struct.
// ----------------------------------------------------------------------------
package mda_pkg;

  localparam int MAX_RANK        = 4;
  localparam int RANK_IDX_W      = $clog2(MAX_RANK);
  localparam int EXTENT_WIDTH    = 13;
  localparam int CFG_REG_COUNT   = 2 * MAX_RANK;
  localparam int CFG_INDEX_WIDTH = $clog2(CFG_REG_COUNT);

  // register map: extents first, lower bounds after them
  localparam int CFG_EXTENT_BASE = 0;
  localparam int CFG_BOUND_BASE  = MAX_RANK;

  localparam int DEF_MEM_DEPTH   = 4096;
  localparam int DEF_ELEM_WIDTH  = 32;
  localparam int DEF_INDEX_WIDTH = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SIZE  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } command_t;

  typedef struct packed {
    logic    valid;
    logic    write;
    status_t status;
  } acc_ctl_t;

  typedef struct packed {
    logic busy;
    logic size_fits;
  } cfg_state_t;

endpackage

[src/mda_if.sv]
// ----------------------------------------------------------------------------
// mda_if: request and response channels of the array store
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface mda_req_if #(
  parameter int INDEX_WIDTH = mda_pkg::DEF_INDEX_WIDTH,
  parameter int ELEM_WIDTH  = mda_pkg::DEF_ELEM_WIDTH
);
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [INDEX_WIDTH-1:0] index_0;
  logic [INDEX_WIDTH-1:0] index_1;
  logic [INDEX_WIDTH-1:0] index_2;
  logic [INDEX_WIDTH-1:0] index_3;
  logic [ELEM_WIDTH-1:0]  write_data;

  modport source (output valid, command, index_0, index_1, index_2, index_3, write_data,
                  input ready);
  modport sink   (input valid, command, index_0, index_1, index_2, index_3, write_data,
                  output ready);
endinterface

interface mda_rsp_if #(
  parameter int ELEM_WIDTH   = mda_pkg::DEF_ELEM_WIDTH,
  parameter int OFFSET_WIDTH = $clog2(mda_pkg::DEF_MEM_DEPTH)
);
  logic                    valid;
  logic                    ready;
  logic [ELEM_WIDTH-1:0]   read_data;
  logic [OFFSET_WIDTH-1:0] element_offset;
  logic [1:0]              status;

  modport source (output valid, read_data, element_offset, status, input ready);
  modport sink   (input valid, read_data, element_offset, status, output ready);
endinterface

[src/multidim_array_access.sv]
// ----------------------------------------------------------------------------
// multidim_array_access: row-major multidimensional array store
// Up to four dimensions with configurable extents and lower bounds; each
// request reads or writes one element after a bounds and size check.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | command, index_0..index_3, write_data
//  rsp     | out | valid/ready | read_data, element_offset, status
//  cfg     | in  | cfg_we      | cfg_index, cfg_data (write only)
//
//  One request per cycle while ready is high; a result passes stages A, B and
//  C before it appears. After reset a clearing pass zeroes the store with ready
//  low. A register write rebuilds the strides with one multiply per dimension,
//  holding ready low until the stride walk ends.
//  A stalled response holds the whole pipeline; ready follows combinationally.
// ----------------------------------------------------------------------------
module multidim_array_access #(
  parameter int MEM_DEPTH   = mda_pkg::DEF_MEM_DEPTH,
  parameter int ELEM_WIDTH  = mda_pkg::DEF_ELEM_WIDTH,
  parameter int INDEX_WIDTH = mda_pkg::DEF_INDEX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mda_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [((INDEX_WIDTH > mda_pkg::EXTENT_WIDTH) ?
                 INDEX_WIDTH : mda_pkg::EXTENT_WIDTH)-1:0] cfg_data,
  mda_req_if.sink                             req,
  mda_rsp_if.source                           rsp
);

  localparam int CFG_WIDTH = (INDEX_WIDTH > mda_pkg::EXTENT_WIDTH) ?
                             INDEX_WIDTH : mda_pkg::EXTENT_WIDTH;
  localparam int SW   = $clog2(MEM_DEPTH + 2);
  localparam int OW   = $clog2(MEM_DEPTH);
  localparam int RANK = mda_pkg::MAX_RANK;

  logic [RANK-1:0][mda_pkg::EXTENT_WIDTH-1:0] extent;
  logic [RANK-1:0][INDEX_WIDTH-1:0]           lower_bound;
  logic [RANK-1:0][SW-1:0]                    stride;
  mda_pkg::cfg_state_t                        cfg_state;

  logic [RANK-1:0][INDEX_WIDTH-1:0]           index;
  logic                                       en;
  logic                                       take;
  logic                                       clearing;

  mda_pkg::acc_ctl_t                          b_ctl;
  logic [OW-1:0]                              b_offset;
  logic [ELEM_WIDTH-1:0]                      b_wdata;
  mda_pkg::acc_ctl_t                          c_ctl;
  logic [OW-1:0]                              c_offset;
  logic [ELEM_WIDTH-1:0]                      rdata;
  logic                                       c_ok;

  // advance everything unless a finished result is held
  assign en        = !c_ctl.valid || rsp.ready;
  assign req.ready = en && !cfg_state.busy && !clearing;
  assign take      = req.valid && req.ready;

  assign index[0] = req.index_0;
  assign index[1] = req.index_1;
  assign index[2] = req.index_2;
  assign index[3] = req.index_3;

  mda_cfg #(
    .MEM_DEPTH   (MEM_DEPTH),
    .INDEX_WIDTH (INDEX_WIDTH),
    .CFG_WIDTH   (CFG_WIDTH),
    .SW          (SW)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .extent      (extent),
    .lower_bound (lower_bound),
    .stride      (stride),
    .cfg_state   (cfg_state)
  );

  mda_addr #(
    .MEM_DEPTH   (MEM_DEPTH),
    .ELEM_WIDTH  (ELEM_WIDTH),
    .INDEX_WIDTH (INDEX_WIDTH),
    .SW          (SW),
    .OW          (OW)
  ) u_addr (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .take        (take),
    .command     (req.command),
    .index       (index),
    .write_data  (req.write_data),
    .extent      (extent),
    .lower_bound (lower_bound),
    .stride      (stride),
    .size_fits   (cfg_state.size_fits),
    .b_ctl       (b_ctl),
    .b_offset    (b_offset),
    .b_wdata     (b_wdata)
  );

  mda_store #(
    .MEM_DEPTH  (MEM_DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .OW         (OW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .b_ctl    (b_ctl),
    .b_offset (b_offset),
    .b_wdata  (b_wdata),
    .clearing (clearing),
    .c_ctl    (c_ctl),
    .c_offset (c_offset),
    .rdata    (rdata)
  );

  assign c_ok               = c_ctl.status == mda_pkg::ST_OK;
  assign rsp.valid          = c_ctl.valid;
  assign rsp.read_data      = (c_ok && !c_ctl.write) ? rdata : '0;
  assign rsp.element_offset = c_ok ? c_offset : '0;
  assign rsp.status         = c_ctl.status;

endmodule

[src/mda_cfg.sv]
// ----------------------------------------------------------------------------
// mda_cfg: configuration registers and stride sequencer
// Holds extents and lower bounds; after a write, walks the dimensions from
// the innermost out, one multiply per cycle, to rebuild strides and size_fits.
// ----------------------------------------------------------------------------
module mda_cfg #(
  parameter int MEM_DEPTH   = mda_pkg::DEF_MEM_DEPTH,
  parameter int INDEX_WIDTH = mda_pkg::DEF_INDEX_WIDTH,
  parameter int CFG_WIDTH   = INDEX_WIDTH,
  parameter int SW          = $clog2(MEM_DEPTH + 2)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mda_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_WIDTH-1:0]                   cfg_data,
  output logic [mda_pkg::MAX_RANK-1:0][mda_pkg::EXTENT_WIDTH-1:0] extent,
  output logic [mda_pkg::MAX_RANK-1:0][INDEX_WIDTH-1:0]           lower_bound,
  output logic [mda_pkg::MAX_RANK-1:0][SW-1:0]                    stride,
  output mda_pkg::cfg_state_t                    cfg_state
);

  localparam int EW = mda_pkg::EXTENT_WIDTH;
  localparam int RW = mda_pkg::RANK_IDX_W;
  localparam int CW = mda_pkg::CFG_INDEX_WIDTH;
  localparam int PW = SW + EW;
  localparam logic [SW-1:0] SAT_PROD = SW'(MEM_DEPTH + 1);

  logic          busy;
  logic          size_fits;
  logic [RW-1:0] dim;
  logic [SW-1:0] prod;
  logic [PW-1:0] prod_full;
  logic [SW-1:0] prod_next;
  logic          reg_hit;
  logic          is_extent;
  logic [CW-1:0] bound_pos;

  assign reg_hit   = cfg_we && ({1'b0, cfg_index} < (CW + 1)'(mda_pkg::CFG_REG_COUNT));
  assign is_extent = cfg_index < CW'(mda_pkg::CFG_BOUND_BASE);
  assign bound_pos = cfg_index - CW'(mda_pkg::CFG_BOUND_BASE);

  assign prod_full = {{EW{1'b0}}, prod} * {{SW{1'b0}}, extent[dim]};
  // saturate once the product is already too large for the store
  assign prod_next = (prod_full > PW'(MEM_DEPTH)) ? SAT_PROD : prod_full[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < mda_pkg::MAX_RANK; d++) begin
        extent[d]      <= EW'(1);
        lower_bound[d] <= '0;
        stride[d]      <= SW'(1);
      end
      busy      <= 1'b0;
      size_fits <= 1'b1;
      dim       <= '0;
      prod      <= SW'(1);
    end else if (reg_hit) begin
      if (is_extent) begin
        extent[cfg_index[RW-1:0]] <= cfg_data[EW-1:0];
      end else begin
        lower_bound[bound_pos[RW-1:0]] <= cfg_data[INDEX_WIDTH-1:0];
      end
      // restart the stride walk from the innermost dimension
      busy <= 1'b1;
      dim  <= RW'(mda_pkg::MAX_RANK - 1);
      prod <= SW'(1);
    end else if (busy) begin
      stride[dim] <= prod;
      prod        <= prod_next;
      dim         <= dim - RW'(1);
      if (dim == '0) begin
        busy      <= 1'b0;
        size_fits <= prod_next <= SW'(MEM_DEPTH);
      end
    end
  end

  assign cfg_state.busy      = busy;
  assign cfg_state.size_fits = size_fits;

  a_write_starts_walk: assert property (@(posedge clk) disable iff (rst)
    reg_hit |=> busy && dim == RW'(mda_pkg::MAX_RANK - 1))
    else $error("stride walk did not restart after a register write");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    busy && !reg_hit && dim == '0 |=> !busy)
    else $error("stride walk ran past the outermost dimension");

endmodule

[src/mda_addr.sv]
// ----------------------------------------------------------------------------
// mda_addr: bounds check and offset generation
// Stage A registers the request; stage B registers the access status and the
// per-dimension products. The offset is the sum of the stage B products.
// ----------------------------------------------------------------------------
module mda_addr #(
  parameter int MEM_DEPTH   = mda_pkg::DEF_MEM_DEPTH,
  parameter int ELEM_WIDTH  = mda_pkg::DEF_ELEM_WIDTH,
  parameter int INDEX_WIDTH = mda_pkg::DEF_INDEX_WIDTH,
  parameter int SW          = $clog2(MEM_DEPTH + 2),
  parameter int OW          = $clog2(MEM_DEPTH)
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic                                                   take,
  input  logic                                                   command,
  input  logic [mda_pkg::MAX_RANK-1:0][INDEX_WIDTH-1:0]           index,
  input  logic [ELEM_WIDTH-1:0]                                  write_data,
  input  logic [mda_pkg::MAX_RANK-1:0][mda_pkg::EXTENT_WIDTH-1:0] extent,
  input  logic [mda_pkg::MAX_RANK-1:0][INDEX_WIDTH-1:0]           lower_bound,
  input  logic [mda_pkg::MAX_RANK-1:0][SW-1:0]                    stride,
  input  logic                                                   size_fits,
  output mda_pkg::acc_ctl_t                                      b_ctl,
  output logic [OW-1:0]                                          b_offset,
  output logic [ELEM_WIDTH-1:0]                                  b_wdata
);

  localparam int RANK = mda_pkg::MAX_RANK;
  localparam int EW   = mda_pkg::EXTENT_WIDTH;
  localparam int IW   = INDEX_WIDTH;
  localparam int HW   = ((IW > EW) ? IW : EW) + 1;

  logic                           a_valid;
  logic                           a_cmd;
  logic [RANK-1:0][IW-1:0]        a_idx;
  logic [ELEM_WIDTH-1:0]          a_wdata;

  logic [RANK-1:0]                in_dim;
  logic [RANK-1:0][OW-1:0]        part;
  mda_pkg::status_t               a_status;

  logic [RANK-1:0][OW-1:0]        b_part;

  always_comb begin
    logic [HW-1:0]    upper;
    logic [IW-1:0]    diff;
    logic [IW+SW-1:0] full;
    for (int d = 0; d < RANK; d++) begin
      upper     = HW'(lower_bound[d]) + HW'(extent[d]);
      diff      = a_idx[d] - lower_bound[d];
      full      = {{SW{1'b0}}, diff} * {{IW{1'b0}}, stride[d]};
      in_dim[d] = (a_idx[d] >= lower_bound[d]) && (HW'(a_idx[d]) < upper);
      // in range, each product stays below the depth; keep the low bits
      part[d]   = full[OW-1:0];
    end
  end

  always_comb begin
    priority if (!size_fits) begin
      a_status = mda_pkg::ST_SIZE;
    end else if (!(&in_dim)) begin
      a_status = mda_pkg::ST_RANGE;
    end else begin
      a_status = mda_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      a_cmd   <= command;
      a_idx   <= index;
      a_wdata <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctl.valid <= 1'b0;
    end else if (en) begin
      b_ctl.valid <= a_valid;
    end
    if (en) begin
      b_ctl.write  <= a_cmd == mda_pkg::CMD_WRITE;
      b_ctl.status <= a_status;
      b_part       <= part;
      b_wdata      <= a_wdata;
    end
  end

  always_comb begin
    b_offset = '0;
    for (int d = 0; d < RANK; d++) begin
      b_offset = b_offset + b_part[d];
    end
  end

  a_offset_in_store: assert property (@(posedge clk) disable iff (rst)
    b_ctl.valid && b_ctl.status == mda_pkg::ST_OK |-> {1'b0, b_offset} < (OW + 1)'(MEM_DEPTH))
    else $error("offset of an in-range access lies outside the store");

endmodule

[src/mda_store.sv]
// ----------------------------------------------------------------------------
// mda_store: element memory with clearing pass and result stage
// One write port: the clearing sweep or a write in stage B. Read data and the
// result stage C register together on the pipeline enable.
// ----------------------------------------------------------------------------
module mda_store #(
  parameter int MEM_DEPTH  = mda_pkg::DEF_MEM_DEPTH,
  parameter int ELEM_WIDTH = mda_pkg::DEF_ELEM_WIDTH,
  parameter int OW         = $clog2(MEM_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  mda_pkg::acc_ctl_t     b_ctl,
  input  logic [OW-1:0]         b_offset,
  input  logic [ELEM_WIDTH-1:0] b_wdata,
  output logic                  clearing,
  output mda_pkg::acc_ctl_t     c_ctl,
  output logic [OW-1:0]         c_offset,
  output logic [ELEM_WIDTH-1:0] rdata
);

  logic [ELEM_WIDTH-1:0] mem [MEM_DEPTH];

  logic [OW-1:0]         clr_addr;
  logic                  mem_we;
  logic [OW-1:0]         mem_addr;
  logic [ELEM_WIDTH-1:0] mem_wdata;

  assign mem_we    = clearing ||
                     (en && b_ctl.valid && b_ctl.write && b_ctl.status == mda_pkg::ST_OK);
  assign mem_addr  = clearing ? clr_addr : b_offset;
  assign mem_wdata = clearing ? '0 : b_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + OW'(1);
      if (clr_addr == OW'(MEM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (en) begin
      rdata <= mem[b_offset];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctl.valid <= 1'b0;
    end else if (en) begin
      c_ctl.valid <= b_ctl.valid;
    end
    if (en) begin
      c_ctl.write  <= b_ctl.write;
      c_ctl.status <= b_ctl.status;
      c_offset     <= b_offset;
    end
  end

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !b_ctl.valid && !c_ctl.valid)
    else $error("request reached the store during the clearing pass");

  a_clear_covers_store: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == OW'(MEM_DEPTH - 1))
    else $error("clearing pass stopped before the last entry");

endmodule

[bench/tb_multidim_array_access.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multidim_array_access: self-checking bench for the row-major array store
// Drives read and write requests through a series of shapes (extents and
// lower bounds), mirrors the store and the bounds and size checks in a
// shadow, and compares every response field against it in order.
// ----------------------------------------------------------------------------
module tb_multidim_array_access;

  localparam int IDX_W       = mda_pkg::DEF_INDEX_WIDTH;
  localparam int ELEM_W      = mda_pkg::DEF_ELEM_WIDTH;
  localparam int DEPTH       = mda_pkg::DEF_MEM_DEPTH;
  localparam int OFF_W       = $clog2(DEPTH);
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    mda_pkg::command_t     command;
    logic [IDX_W-1:0]      index_0;
    logic [IDX_W-1:0]      index_1;
    logic [IDX_W-1:0]      index_2;
    logic [IDX_W-1:0]      index_3;
    logic [ELEM_W-1:0]     write_data;
  } access_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] read_data;
    logic [OFF_W-1:0]  element_offset;
    mda_pkg::status_t  status;
  } access_result_t;

  // Shadow of the array store: shape registers, strides, contents and the
  // responses still owed by the block.
  class array_shadow;
    logic [mda_pkg::EXTENT_WIDTH-1:0] extent [mda_pkg::MAX_RANK];
    logic [IDX_W-1:0]                 lower_bound [mda_pkg::MAX_RANK];
    longint unsigned                  stride [mda_pkg::MAX_RANK];
    bit                               size_fits;
    logic [ELEM_W-1:0]                elements [DEPTH];
    access_result_t                   pending_results [$];
    int unsigned                      errors;

    function void clear();
      for (int d = 0; d < mda_pkg::MAX_RANK; d++) begin
        extent[d]      = mda_pkg::EXTENT_WIDTH'(1);
        lower_bound[d] = '0;
      end
      for (int a = 0; a < DEPTH; a++) elements[a] = '0;
      errors = 0;
      restride();
    endfunction

    function void restride();
      longint unsigned prod;
      prod = 1;
      for (int d = mda_pkg::MAX_RANK - 1; d >= 0; d--) begin
        stride[d] = prod;
        prod = prod * 64'(extent[d]);
        if (prod > 64'(DEPTH)) prod = 64'(DEPTH + 1);
      end
      size_fits = (prod <= 64'(DEPTH));
    endfunction

    function void write_reg(int unsigned idx, logic [IDX_W-1:0] value);
      if (idx < mda_pkg::CFG_BOUND_BASE)
        extent[idx - mda_pkg::CFG_EXTENT_BASE] = value[mda_pkg::EXTENT_WIDTH-1:0];
      else lower_bound[idx - mda_pkg::CFG_BOUND_BASE] = value;
      restride();
    endfunction

    function void note_request(access_req_t rq);
      access_result_t  want;
      logic [IDX_W-1:0] idx [mda_pkg::MAX_RANK];
      longint unsigned offs, iv, lv, ev;
      bit              in_range;
      idx[0] = rq.index_0;
      idx[1] = rq.index_1;
      idx[2] = rq.index_2;
      idx[3] = rq.index_3;
      want.read_data      = '0;
      want.element_offset = '0;
      if (!size_fits) begin
        want.status = mda_pkg::ST_SIZE;
      end else begin
        offs     = 0;
        in_range = 1'b1;
        for (int d = 0; d < mda_pkg::MAX_RANK; d++) begin
          iv = 64'(idx[d]);
          lv = 64'(lower_bound[d]);
          ev = 64'(extent[d]);
          // upper limit is formed wide, so it never wraps
          if (iv < lv || iv >= lv + ev) in_range = 1'b0;
          else offs += (iv - lv) * stride[d];
        end
        if (!in_range) begin
          want.status = mda_pkg::ST_RANGE;
        end else begin
          offs = offs % DEPTH;
          want.status         = mda_pkg::ST_OK;
          want.element_offset = OFF_W'(offs);
          if (rq.command == mda_pkg::CMD_WRITE) elements[offs] = rq.write_data;
          else want.read_data = elements[offs];
        end
      end
      pending_results.push_back(want);
    endfunction

    function void check_response(logic [ELEM_W-1:0] data, logic [OFF_W-1:0] offset,
                                 logic [1:0] status);
      access_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: response with no request outstanding: data %h offset %0d status %0d",
                 $time, data, offset, status);
        return;
      end
      want = pending_results.pop_front();
      if (data !== want.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, data);
      end
      if (offset !== want.element_offset) begin
        errors++;
        $display("%0t: element_offset expected %0d actual %0d", $time,
                 want.element_offset, offset);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [mda_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [IDX_W-1:0]                    cfg_data;

  mda_req_if req_ch ();
  mda_rsp_if rsp_ch ();

  multidim_array_access u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  array_shadow shadow;
  bit          no_idle;
  bit          hold_armed;

  initial begin
    shadow = new();
    shadow.clear();
  end

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Response side: random back-pressure, one long hold-off when armed.
  initial begin : rsp_side
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        shadow.check_response(rsp_ch.read_data, rsp_ch.element_offset, rsp_ch.status);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 31);
      end
    end
  end

  // Offer one request, with random gaps ahead of it; return once accepted.
  task automatic send_request(access_req_t rq);
    while (!no_idle && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= rq.command;
    req_ch.index_0    <= rq.index_0;
    req_ch.index_1    <= rq.index_1;
    req_ch.index_2    <= rq.index_2;
    req_ch.index_3    <= rq.index_3;
    req_ch.write_data <= rq.write_data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    shadow.note_request(rq);
  endtask

  task automatic issue(mda_pkg::command_t cmd, int unsigned i0, int unsigned i1,
                       int unsigned i2, int unsigned i3, logic [ELEM_W-1:0] wd);
    access_req_t rq;
    rq.command    = cmd;
    rq.index_0    = IDX_W'(i0);
    rq.index_1    = IDX_W'(i1);
    rq.index_2    = IDX_W'(i2);
    rq.index_3    = IDX_W'(i3);
    rq.write_data = wd;
    send_request(rq);
  endtask

  // Drop valid and wait until every owed response is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
  endtask

  // Write all eight shape registers back to back; the block must be idle.
  task automatic apply_config(int unsigned e0, int unsigned e1, int unsigned e2,
                              int unsigned e3, int unsigned l0, int unsigned l1,
                              int unsigned l2, int unsigned l3, bit junk);
    logic [IDX_W-1:0] vals [mda_pkg::CFG_REG_COUNT];
    vals[mda_pkg::CFG_EXTENT_BASE + 0] = IDX_W'(mda_pkg::EXTENT_WIDTH'(e0));
    vals[mda_pkg::CFG_EXTENT_BASE + 1] = IDX_W'(mda_pkg::EXTENT_WIDTH'(e1));
    vals[mda_pkg::CFG_EXTENT_BASE + 2] = IDX_W'(mda_pkg::EXTENT_WIDTH'(e2));
    vals[mda_pkg::CFG_EXTENT_BASE + 3] = IDX_W'(mda_pkg::EXTENT_WIDTH'(e3));
    vals[mda_pkg::CFG_BOUND_BASE + 0]  = IDX_W'(l0);
    vals[mda_pkg::CFG_BOUND_BASE + 1]  = IDX_W'(l1);
    vals[mda_pkg::CFG_BOUND_BASE + 2]  = IDX_W'(l2);
    vals[mda_pkg::CFG_BOUND_BASE + 3]  = IDX_W'(l3);
    // put noise above the extent field; the block must drop it
    if (junk)
      for (int d = 0; d < mda_pkg::MAX_RANK; d++)
        vals[mda_pkg::CFG_EXTENT_BASE + d][IDX_W-1:mda_pkg::EXTENT_WIDTH] =
          (IDX_W - mda_pkg::EXTENT_WIDTH)'($urandom);
    for (int i = 0; i < mda_pkg::CFG_REG_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= mda_pkg::CFG_INDEX_WIDTH'(i);
      cfg_data  <= vals[i];
      shadow.write_reg(i, vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Pick a shape that fits the store, rank one to four, with mixed bounds.
  task automatic random_config();
    int unsigned ext [mda_pkg::MAX_RANK];
    int unsigned lb [mda_pkg::MAX_RANK];
    int unsigned budget, rank, r;
    budget = DEPTH;
    rank   = $urandom_range(mda_pkg::MAX_RANK, 1);
    for (int d = mda_pkg::MAX_RANK - 1; d >= 0; d--) begin
      if (d < mda_pkg::MAX_RANK - rank) begin
        ext[d] = 1;
        lb[d]  = 0;
      end else begin
        if ($urandom_range(3) == 0) ext[d] = $urandom_range(budget, 1);
        else ext[d] = $urandom_range((budget < 16) ? budget : 16, 1);
        budget = budget / ext[d];
        r = $urandom_range(9);
        if (r < 5) lb[d] = $urandom_range(20);
        else if (r < 8) lb[d] = $urandom_range(16'hFFFF);
        else lb[d] = 16'hFFFF - $urandom_range(40);
      end
    end
    apply_config(ext[0], ext[1], ext[2], ext[3], lb[0], lb[1], lb[2], lb[3], 1'b1);
  endtask

  // Mostly in-range accesses for the current shape, some one index off,
  // some fully random.
  function automatic access_req_t make_request();
    access_req_t      rq;
    logic [IDX_W-1:0] idx [mda_pkg::MAX_RANK];
    int unsigned      pick, bad_dim, span, base, v;
    pick          = $urandom_range(99);
    bad_dim       = $urandom_range(mda_pkg::MAX_RANK - 1);
    rq.command    = mda_pkg::command_t'($urandom_range(1));
    rq.write_data = $urandom;
    for (int d = 0; d < mda_pkg::MAX_RANK; d++) begin
      span = 32'(shadow.extent[d]);
      base = 32'(shadow.lower_bound[d]);
      if (pick >= 90 || span == 0) begin
        v = $urandom;
      end else begin
        v = base + $urandom_range(span - 1);
        if (v > 16'hFFFF) v = $urandom_range(16'hFFFF, base);
        if (pick >= 75 && d == bad_dim) begin
          case ($urandom_range(2))
            0:       v = base - 1;
            1:       v = base + span;
            default: v = $urandom;
          endcase
        end
      end
      idx[d] = IDX_W'(v);
    end
    rq.index_0 = idx[0];
    rq.index_1 = idx[1];
    rq.index_2 = idx[2];
    rq.index_3 = idx[3];
    return rq;
  endfunction

  initial begin : stimulus
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.command    = mda_pkg::CMD_READ;
    req_ch.index_0    = '0;
    req_ch.index_1    = '0;
    req_ch.index_2    = '0;
    req_ch.index_3    = '0;
    req_ch.write_data = '0;
    no_idle           = 1'b0;
    hold_armed        = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset shape: a single element at index zero
    issue(mda_pkg::CMD_READ,  0, 0, 0, 0, 32'h0);
    issue(mda_pkg::CMD_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    issue(mda_pkg::CMD_READ,  0, 0, 0, 0, 32'h0);
    issue(mda_pkg::CMD_READ,  0, 0, 0, 1, 32'h0);
    issue(mda_pkg::CMD_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
    drain();

    // full store, last element and one past the outer edge
    apply_config(4, 8, 16, 8, 0, 0, 0, 0, 1'b0);
    issue(mda_pkg::CMD_WRITE, 3, 7, 15, 7, 32'hA5A5_5A5A);
    issue(mda_pkg::CMD_READ,  3, 7, 15, 7, 32'h0);
    issue(mda_pkg::CMD_READ,  0, 0, 0, 0, 32'h0);
    issue(mda_pkg::CMD_READ,  4, 0, 0, 0, 32'h0);
    issue(mda_pkg::CMD_WRITE, 1, 2, 3, 4, 32'h0);
    drain();

    // top bounds: the upper limit passes 65535 and admits the top index
    apply_config(1, 1, 1, 4096, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    issue(mda_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h1234_5678);
    issue(mda_pkg::CMD_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 32'h0);
    issue(mda_pkg::CMD_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0);
    drain();

    apply_config(1, 1, 1, 4096, 0, 0, 0, 0, 1'b0);
    issue(mda_pkg::CMD_READ, 0, 0, 0, 4095, 32'h0);
    issue(mda_pkg::CMD_READ, 0, 0, 0, 4096, 32'h0);
    drain();

    // zero extent: nothing is ever in range
    apply_config(0, 1, 1, 1, 0, 0, 0, 0, 1'b0);
    issue(mda_pkg::CMD_READ,  0, 0, 0, 0, 32'h0);
    issue(mda_pkg::CMD_WRITE, 0, 0, 0, 0, 32'hDEAD_BEEF);
    drain();

    // extent beyond the store, then a product beyond the store
    apply_config(1, 1, 1, 8191, 0, 0, 0, 0, 1'b0);
    issue(mda_pkg::CMD_WRITE, 0, 0, 0, 0, 32'hDEAD_BEEF);
    issue(mda_pkg::CMD_READ,  0, 0, 0, 0, 32'h0);
    drain();
    apply_config(64, 65, 1, 1, 0, 0, 0, 0, 1'b0);
    issue(mda_pkg::CMD_READ, 0, 0, 0, 0, 32'h0);
    drain();

    // rank two with nonzero bounds
    apply_config(1, 1, 64, 64, 0, 0, 100, 200, 1'b0);
    issue(mda_pkg::CMD_WRITE, 0, 0, 163, 263, 32'h0F0F_F0F0);
    issue(mda_pkg::CMD_READ,  0, 0, 100, 200, 32'h0);
    drain();

    for (int p = 0; p < 11; p++) begin
      random_config();
      // one phase runs without gaps and stalls the response side for a while
      no_idle = (p == 4);
      if (p == 4) hold_armed = 1'b1;
      repeat (PHASE_ITEMS) send_request(make_request());
      drain();
    end
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
